// ===== rtl/core/sstf_pkg.sv =====
package sstf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CYL_BITS    = 16;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CYL_FIELD_W   = 16;
    localparam int COUNT_FIELD_W = 7;

    localparam logic [1:0] ACT_PUT     = 2'd0;
    localparam logic [1:0] ACT_OLDEST  = 2'd1;
    localparam logic [1:0] ACT_NEWEST  = 2'd2;
    localparam logic [1:0] ACT_CLOSEST = 2'd3;

    typedef struct packed {
        logic [1:0]             action;
        logic [CYL_FIELD_W-1:0] cylinder;
        logic [CYL_FIELD_W-1:0] head_position;
    } t_req;

    typedef struct packed {
        logic [CYL_FIELD_W-1:0]   value;
        logic                     valid_res;
        logic                     dropped;
        logic [COUNT_FIELD_W-1:0] count;
    } t_rsp;

endpackage

// ===== rtl/core/sstf_request_queue_core.sv =====
// Age-ordered queue of disk cylinder requests for shortest-seek-first service.
// The input channel (i_in_valid, o_in_ready, i_in_data) carries one request
// beat: put, pull oldest, pop newest or pull closest to the head position.
// Every request produces exactly one response beat on the output channel
// (o_out_valid, i_out_ready, o_out_data) with the removed cylinder, a valid
// flag, a dropped flag for a put into a full queue, and the entry count.
// Entries live in a single-port-read, single-port-write memory, oldest first.
// Put, and any pull on an empty queue, go straight to the response. Pull
// oldest and pop newest read the entry, then close the gap one entry per
// cycle. Pull closest first streams all count entries through one shared
// distance compare, then closes the gap in the same way.
// The block takes one request at a time; o_in_ready is high only when idle.
// A finished response waits in the output register while the receiver
// stalls; a new request is taken meanwhile, and its response holds back
// until the previous beat is taken.
// Reset empties the queue; memory contents need no clearing.
module sstf_request_queue_core
    import sstf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_FETCH2 = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [CYL_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [CYL_BITS-1:0] r_rd_data;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_src, n_src;
    logic                r_rv, n_rv;
    logic [IDX_W-1:0]    r_ri, n_ri;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out_data, n_out_data;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CYL_BITS-1:0] r_head, n_head;
    logic [CYL_BITS-1:0] r_best, n_best;
    logic [CYL_BITS-1:0] r_val, n_val;
    logic                r_valid_res, n_valid_res;
    logic                r_dropped, n_dropped;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    logic [CYL_BITS-1:0] mem_wd;
    logic [IDX_W-1:0]    mem_ra;
    logic [CYL_BITS-1:0] w_dist;

    // The shared compare unit: distance from the head to the word just read.
    assign w_dist = (r_head >= r_rd_data) ? (r_head - r_rd_data) : (r_rd_data - r_head);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_src       = r_src;
        n_rv        = 1'b0;
        n_ri        = r_ri;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_pos       = r_pos;
        n_head      = r_head;
        n_best      = r_best;
        n_val       = r_val;
        n_valid_res = r_valid_res;
        n_dropped   = r_dropped;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_ra      = r_src[IDX_W-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_head      = CYL_BITS'(i_in_data.head_position);
                    n_val       = '0;
                    n_valid_res = 1'b0;
                    n_dropped   = 1'b0;
                    priority if (i_in_data.action == ACT_PUT) begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_dropped = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = r_count[IDX_W-1:0];
                            mem_wd  = CYL_BITS'(i_in_data.cylinder);
                            n_count = r_count + 1'b1;
                        end
                        n_state = ST_FIN;
                    end else if (r_count == '0) begin
                        n_state = ST_FIN;
                    end else if (i_in_data.action == ACT_OLDEST) begin
                        n_pos   = '0;
                        n_state = ST_FETCH;
                    end else if (i_in_data.action == ACT_NEWEST) begin
                        n_pos   = IDX_W'(r_count - 1'b1);
                        n_state = ST_FETCH;
                    end else begin
                        n_src   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Strict less-than keeps the oldest entry on a tie.
                if (r_rv && ((r_ri == '0) || (w_dist < r_best))) begin
                    n_best = w_dist;
                    n_pos  = r_ri;
                    n_val  = r_rd_data;
                end
                if (r_src < r_count) begin
                    mem_ra = r_src[IDX_W-1:0];
                    n_rv   = 1'b1;
                    n_ri   = r_src[IDX_W-1:0];
                    n_src  = r_src + 1'b1;
                end else if (!r_rv) begin
                    n_src   = CNT_W'(r_pos) + 1'b1;
                    n_state = ST_SHIFT;
                end
            end
            ST_FETCH: begin
                mem_ra  = r_pos;
                n_state = ST_FETCH2;
            end
            ST_FETCH2: begin
                n_val   = r_rd_data;
                n_src   = CNT_W'(r_pos) + 1'b1;
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                // Each word read at index i is written to i - 1 in the next cycle.
                if (r_rv) begin
                    mem_we = 1'b1;
                    mem_wa = r_ri - 1'b1;
                    mem_wd = r_rd_data;
                end
                if (r_src < r_count) begin
                    mem_ra = r_src[IDX_W-1:0];
                    n_rv   = 1'b1;
                    n_ri   = r_src[IDX_W-1:0];
                    n_src  = r_src + 1'b1;
                end else if (!r_rv) begin
                    n_count     = r_count - 1'b1;
                    n_valid_res = 1'b1;
                    n_state     = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_data.value     = CYL_FIELD_W'(r_val);
                    n_out_data.valid_res = r_valid_res;
                    n_out_data.dropped   = r_dropped;
                    n_out_data.count     = COUNT_FIELD_W'(r_count);
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_ri        <= n_ri;
        r_out_data  <= n_out_data;
        r_pos       <= n_pos;
        r_head      <= n_head;
        r_best      <= n_best;
        r_val       <= n_val;
        r_valid_res <= n_valid_res;
        r_dropped   <= n_dropped;
    end

endmodule
